// ----- rtl/b91_pkg.sv -----
// Shared constants, types and the digit-to-character table for the base-91 encoder.
`default_nettype none

package b91_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int B91_BASE    = 91;
    localparam int NUM_W       = 64;
    localparam int MIN_W       = 5;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 7;
    // 91^10 > 2^64 - 1, so ten base-91 digits always suffice
    localparam int NUM_CELLS   = 10;
    localparam int CELL_IDX_W  = $clog2(NUM_CELLS);
    localparam int POS_W       = $clog2(MAX_DIGITS);
    localparam int BIT_CNT_W   = $clog2(NUM_W);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam int NUM_PUNCT = 29;
    localparam logic [NUM_PUNCT*8-1:0] B91_PUNCT = "!#$%&()*+,-./:;<=>?@[]^_`{|}~";

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_CONV,
        ST_ALIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctrl;

    function automatic logic [CHAR_W-1:0] b91_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] p;
        logic [CHAR_W-1:0]  c;
        p = 7'(d - 7'd62);
        if (d < 7'd10) begin
            c = 7'(CHAR_ZERO + d);
        end else if (d < 7'd36) begin
            c = 7'(CHAR_UPPER_A + d - 7'd10);
        end else if (d < 7'd62) begin
            c = 7'(CHAR_LOWER_A + d - 7'd36);
        end else if (d < 7'(B91_BASE)) begin
            c = B91_PUNCT[(NUM_PUNCT - 1 - int'(p)) * 8 +: CHAR_W];
        end else begin
            c = CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/int_to_base91_text.sv -----
// Top level of the base-91 text encoder: control, digit cell chain and output register.
`default_nettype none

// Converts a 64-bit unsigned number into base-91 ASCII text, most significant
// character first, left-padded with '0' to i_min_digits (saturated at
// MAX_DIGITS). A zero i_min_digits gives a single transfer with o_error = 1.
// Input: i_in_valid / o_in_ready with i_number and i_min_digits.
// Output: o_out_valid / i_out_ready with o_char_code, o_error, o_last; o_last
// marks the final character of each conversion.
// One item at a time. A chain of ten digit cells takes one bit of the number
// per cycle, then drops leading zero digits above the pad width (up to 9),
// then one character leaves per cycle while the receiver is ready.
// The output register holds its transfer while the receiver stalls; during
// output the chain and counters simply wait. A new item is taken once the
// previous item's last character is in the output register.
// Reset (synchronous, active low) returns to idle and empties the output.
module int_to_base91_text (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [b91_pkg::NUM_W-1:0]  i_number,
    input  wire logic [b91_pkg::MIN_W-1:0]  i_min_digits,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [b91_pkg::CHAR_W-1:0]      o_char_code,
    output logic                            o_error,
    output logic                            o_last
);
    import b91_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [NUM_W-1:0]      r_num;
    logic [NUM_W-1:0]      n_num;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [BIT_CNT_W-1:0]  n_bit_cnt;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      n_pos;
    logic [CELL_IDX_W-1:0] r_top_pos;
    logic [CELL_IDX_W-1:0] n_top_pos;

    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [CHAR_W-1:0]     r_char;
    logic [CHAR_W-1:0]     n_char;
    logic                  r_err;
    logic                  n_err;
    logic                  r_last;
    logic                  n_last;

    t_cell_ctrl            cell_ctrl;
    logic [NUM_CELLS:0]    carry;
    logic [DIGIT_W-1:0]    digit [NUM_CELLS];
    logic [DIGIT_W-1:0]    digit_below [NUM_CELLS];

    logic                  in_xfer;
    logic                  out_free;
    logic [POS_W-1:0]      want_m1;
    logic [POS_W:0]        top_pos_ext;
    logic [POS_W:0]        pos_ext;
    logic [DIGIT_W-1:0]    top_digit;
    logic                  at_top;
    logic                  lead_zone;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign want_m1 = (int'(i_min_digits) > MAX_DIGITS) ? POS_W'(MAX_DIGITS - 1)
                                                        : POS_W'(i_min_digits - 5'd1);
    assign top_pos_ext = (POS_W + 1)'(r_top_pos);
    assign pos_ext     = (POS_W + 1)'(r_pos);
    assign top_digit   = digit[NUM_CELLS-1];
    // while emitting r_pos never drops below r_top_pos; equal means the top cell is next
    assign at_top      = (pos_ext <= top_pos_ext);
    // top cell sits above the padded width: a leading zero there is dropped
    assign lead_zone   = (pos_ext < top_pos_ext);

    // digit chain, cell 0 least significant
    assign carry[0] = r_num[NUM_W-1];
    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
            if (gi == 0) begin : g_bottom
                assign digit_below[gi] = '0;
            end else begin : g_upper
                assign digit_below[gi] = digit[gi-1];
            end
            b91_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (cell_ctrl),
                .i_carry       (carry[gi]),
                .i_digit_below (digit_below[gi]),
                .o_carry       (carry[gi+1]),
                .o_digit       (digit[gi])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_min_digits == '0) ? ST_ERR : ST_CONV;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CONV: begin
                if (r_bit_cnt == '0) begin
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (!lead_zone || top_digit != '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && r_pos == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cell_ctrl   = '0;
        n_num       = r_num;
        n_bit_cnt   = r_bit_cnt;
        n_pos       = r_pos;
        n_top_pos   = r_top_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_err       = r_err;
        n_last      = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    cell_ctrl.clear = 1'b1;
                    n_num     = i_number;
                    n_bit_cnt = BIT_CNT_W'(NUM_W - 1);
                    n_pos     = want_m1;
                    n_top_pos = CELL_IDX_W'(NUM_CELLS - 1);
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = '0;
                    n_err       = 1'b1;
                    n_last      = 1'b1;
                end
            end
            ST_CONV: begin
                cell_ctrl.conv = 1'b1;
                n_num     = {r_num[NUM_W-2:0], 1'b0};
                n_bit_cnt = BIT_CNT_W'(r_bit_cnt - 1'b1);
            end
            ST_ALIGN: begin
                // drop leading zero digits above both the text and the pad width
                if (lead_zone) begin
                    if (top_digit != '0) begin
                        n_pos = POS_W'(r_top_pos);
                    end else begin
                        cell_ctrl.shift = 1'b1;
                        n_top_pos = CELL_IDX_W'(r_top_pos - 1'b1);
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = at_top ? b91_char(top_digit) : CHAR_ZERO;
                    n_err       = 1'b0;
                    n_last      = (r_pos == '0);
                    if (r_pos != '0) begin
                        n_pos = POS_W'(r_pos - 1'b1);
                        if (at_top) begin
                            cell_ctrl.shift = 1'b1;
                            n_top_pos = CELL_IDX_W'(r_top_pos - 1'b1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num     <= n_num;
        r_bit_cnt <= n_bit_cnt;
        r_pos     <= n_pos;
        r_top_pos <= n_top_pos;
        r_char    <= n_char;
        r_err     <= n_err;
        r_last    <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_error     = r_err;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// ----- rtl/b91_cell.sv -----
// One base-91 digit cell: clears on load, doubles-and-adds during conversion, shifts up during alignment and output.
`default_nettype none

module b91_cell (
    input  wire logic                        i_clk,
    input  wire b91_pkg::t_cell_ctrl         i_ctrl,
    input  wire logic                        i_carry,
    input  wire logic [b91_pkg::DIGIT_W-1:0] i_digit_below,
    output logic                             o_carry,
    output logic [b91_pkg::DIGIT_W-1:0]      o_digit
);
    import b91_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W:0]   dbl;
    logic               wrap;

    // digit * 2 + carry; a result of 91 or more wraps and carries upward
    assign dbl     = {r_digit, i_carry};
    assign wrap    = dbl >= (DIGIT_W + 1)'(B91_BASE);
    assign o_carry = wrap;
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        priority if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.conv) begin
            n_digit = wrap ? DIGIT_W'(dbl - (DIGIT_W + 1)'(B91_BASE)) : DIGIT_W'(dbl);
        end else if (i_ctrl.shift) begin
            n_digit = i_digit_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire
